@@ hdl/adcrr_pkg.sv @@
// shared constants, codes and types of the adc round-robin channel fifos
package adcrr_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int FIFO_DEPTH    = 4;
  localparam int SAMPLE_BITS   = 10;

  localparam int CH_W          = 4;
  localparam int PTR_W         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W        = $clog2(FIFO_DEPTH + 1);
  localparam int RAM_DEPTH     = NUM_CHANNELS * FIFO_DEPTH;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int SCHED_ENTRIES = 16;
  localparam int LEN_W         = 5;
  localparam int TABLE_W       = SCHED_ENTRIES * CH_W;
  localparam int DROP_W        = 16;
  localparam int TOTAL_W       = 32;
  localparam int REQ_W         = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ENABLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_TABLE = 1'd1;

  // decoded request as it sits in the command queue
  typedef struct packed {
    logic                   tick;
    logic                   sample;
    logic                   pop;
    logic                   setena;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] value;
    logic                   en;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [CH_W-1:0]        selected_channel;
    logic                   start_conversion;
    logic [CH_W-1:0]        sample_channel;
    logic                   pop_valid;
    logic [SAMPLE_BITS-1:0] pop_data;
    logic [DROP_W-1:0]      drop_count;
    logic [TOTAL_W-1:0]     tick_total;
    logic [TOTAL_W-1:0]     sample_total;
  } res_t;

endpackage

@@ hdl/adcrr_ram.sv @@
// generic single-write, single-read ram with registered read data
module adcrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/adcrr_front.sv @@
// front end: takes request words, decodes them and queues them for the back end
module adcrr_front import adcrr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                   in_enable_flag,
  output logic                   cq_valid,
  output cmd_t                   cq_cmd,
  input  logic                   cq_pop
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  cmd_t       q_r [2];
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec        = '0;
    dec.ch     = in_channel;
    dec.value  = in_sample_value;
    dec.en     = in_enable_flag;
    unique case (in_req_type)
      REQ_TICK:   dec.tick   = 1'b1;
      REQ_SAMPLE: dec.sample = 1'b1;
      REQ_POP:    dec.pop    = 1'b1;
      REQ_ENABLE: dec.setena = 1'b1;
      default:    dec.tick   = 1'b1;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign cq_valid = (cnt_r != 2'd0);
  assign cq_cmd   = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = cq_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

@@ hdl/adcrr_back.sv @@
// back end: schedule, per-channel queues and counters, result registers
module adcrr_back import adcrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cq_valid,
  input  cmd_t                 cq_cmd,
  output logic                 cq_pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TABLE_W-1:0]   cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output res_t                 out_res
);

  logic [LEN_W-1:0]   sched_len_r;
  logic [TABLE_W-1:0] sched_table_r;
  logic [CH_W-1:0]    sched_entry [SCHED_ENTRIES];

  logic [PTR_W-1:0]   wptr_r [NUM_CHANNELS];
  logic [PTR_W-1:0]   rptr_r [NUM_CHANNELS];
  logic [FILL_W-1:0]  fill_r [NUM_CHANNELS];
  logic [DROP_W-1:0]  drop_r [NUM_CHANNELS];
  logic               ena_r  [NUM_CHANNELS];

  logic [CH_W-1:0]    pos_r, pos_nxt;
  logic [CH_W-1:0]    cur_r, cur_nxt;
  logic [TOTAL_W-1:0] ticks_r, ticks_nxt;
  logic [TOTAL_W-1:0] samples_r, samples_nxt;

  logic               pend_valid_r, pend_valid_nxt;
  res_t               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;

  logic               pend_move, exec;
  logic [LEN_W-1:0]   len_eff, pos_inc, pos_wrap;
  logic               tick_adv;
  logic [CH_W-1:0]    idx;
  logic               ch_ok;
  logic [PTR_W-1:0]   wp, rp, wp_n, rp_n;
  logic [FILL_W-1:0]  fl, fill_n;
  logic [DROP_W-1:0]  dr;
  logic               en_q;
  logic               can_store, do_drop, do_pop, do_ena, clr_q, wr_ptrs;
  logic [RAM_AW-1:0]  base;
  logic               ram_we, ram_re;
  logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < SCHED_ENTRIES; i++) begin
      sched_entry[i] = sched_table_r[i*CH_W +: CH_W];
    end
  end

  // pending stage moves into the output register when that one is free or being taken
  assign pend_move = pend_valid_r && (!out_valid_r || !out_stall);
  assign exec      = cq_valid && (!pend_valid_r || pend_move);
  assign cq_pop    = exec;
  assign cfg_ready = 1'b1;

  always_comb begin
    len_eff  = (sched_len_r > LEN_W'(SCHED_ENTRIES)) ? LEN_W'(SCHED_ENTRIES) : sched_len_r;
    pos_inc  = {1'b0, pos_r} + 1'b1;
    pos_wrap = (pos_inc >= len_eff) ? '0 : pos_inc;
    tick_adv = cq_cmd.tick && (sched_len_r != '0);
    pos_nxt  = tick_adv ? pos_wrap[CH_W-1:0] : pos_r;
    cur_nxt  = tick_adv ? sched_entry[pos_wrap[CH_W-1:0]] : cur_r;
    idx      = (cq_cmd.tick || cq_cmd.sample) ? cur_nxt : cq_cmd.ch;
    ch_ok    = ({1'b0, idx} < (CH_W + 1)'(NUM_CHANNELS));

    wp   = wptr_r[idx];
    rp   = rptr_r[idx];
    fl   = fill_r[idx];
    dr   = drop_r[idx];
    en_q = ena_r[idx];

    can_store = cq_cmd.sample && ch_ok && en_q && (fl < FILL_W'(FIFO_DEPTH));
    do_drop   = cq_cmd.sample && ch_ok && en_q && !(fl < FILL_W'(FIFO_DEPTH));
    do_pop    = cq_cmd.pop && ch_ok && (fl != '0);
    do_ena    = cq_cmd.setena && ch_ok;
    clr_q     = do_ena && !cq_cmd.en;
    wr_ptrs   = can_store || do_pop || clr_q;

    wp_n   = wp;
    rp_n   = rp;
    fill_n = fl;
    if (clr_q) begin
      wp_n   = '0;
      rp_n   = '0;
      fill_n = '0;
    end else if (can_store) begin
      wp_n   = next_slot(wp);
      fill_n = fl + 1'b1;
    end else if (do_pop) begin
      rp_n   = next_slot(rp);
      fill_n = fl - 1'b1;
    end

    base      = RAM_AW'(idx) * RAM_AW'(FIFO_DEPTH);
    ram_we    = exec && can_store;
    ram_re    = exec && do_pop;
    ram_waddr = base + RAM_AW'(wp);
    ram_raddr = base + RAM_AW'(rp);

    ticks_nxt   = cq_cmd.tick ? ticks_r + 1'b1 : ticks_r;
    samples_nxt = cq_cmd.sample ? samples_r + 1'b1 : samples_r;

    pend_nxt                  = '0;
    pend_nxt.selected_channel = cur_nxt;
    pend_nxt.start_conversion = tick_adv;
    pend_nxt.sample_channel   = cq_cmd.sample ? cur_r : '0;
    pend_nxt.pop_valid        = do_pop;
    pend_nxt.drop_count       = !ch_ok ? '0 : (do_drop ? dr + 1'b1 : dr);
    pend_nxt.tick_total       = ticks_nxt;
    pend_nxt.sample_total     = samples_nxt;

    // popped word comes from the ram's read register, loaded along with the pending word
    out_nxt          = pend_r;
    out_nxt.pop_data = pend_r.pop_valid ? ram_rdata : '0;

    pend_valid_nxt = exec || (pend_valid_r && !pend_move);
    out_valid_nxt  = pend_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_len_r   <= '0;
      sched_table_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCHED_LEN:   sched_len_r   <= cfg_wdata[LEN_W-1:0];
        CFG_SCHED_TABLE: sched_table_r <= cfg_wdata;
        default:         sched_len_r   <= sched_len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      cur_r        <= '0;
      ticks_r      <= '0;
      samples_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wptr_r[i] <= '0;
        rptr_r[i] <= '0;
        fill_r[i] <= '0;
        drop_r[i] <= '0;
        ena_r[i]  <= 1'b1;
      end
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (exec) begin
        pos_r     <= pos_nxt;
        cur_r     <= cur_nxt;
        ticks_r   <= ticks_nxt;
        samples_r <= samples_nxt;
        if (wr_ptrs) begin
          wptr_r[idx] <= wp_n;
          rptr_r[idx] <= rp_n;
          fill_r[idx] <= fill_n;
        end
        if (do_drop) begin
          drop_r[idx] <= dr + 1'b1;
        end
        if (do_ena) begin
          ena_r[idx] <= cq_cmd.en;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      pend_r <= pend_nxt;
    end
    if (pend_move) begin
      out_r <= out_nxt;
    end
  end

  adcrr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cq_cmd.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && !pend_move |=> pend_valid_r)
    else $error("pending word lost while output blocked");

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read in the same cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> fl <= FILL_W'(FIFO_DEPTH))
    else $error("channel fill level above queue depth");

  a_pop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    exec && do_pop |=> pend_valid_r && pend_r.pop_valid)
    else $error("pop result not flagged valid");

endmodule

@@ hdl/adc_round_robin_channel_fifos_top.sv @@
// top level of the adc round-robin sequencer with per-channel sample queues
//
// request words come in on the in_ channel (valid/stall): a tick steps the
// round-robin schedule and pulses start_conversion, a sample is filed in the
// queue of the selected channel (dropped and counted when that queue is full),
// a pop returns the oldest sample of a named channel, and an enable request
// switches a channel's queue on or off (off also empties it).
// every request gives exactly one result word on the out_ channel.
// the schedule length and table are written on the cfg_ port (index 0 and 1),
// which is always ready; write it only while no request is in flight.
// throughput: one request per cycle while out_stall is low; the per-channel
// read-modify-write of pointers, fill level and drop counter is done in the
// back end, and the popped sample comes from the store ram's registered read.
// a tick with a schedule length of zero neither steps nor starts a conversion.
// a two-word command queue sits between decode and execution, so in_stall
// rises only when that queue is full while the output is held by out_stall.
// reset is synchronous: counters, pointers and schedule position clear and all
// queues come up enabled and empty; store contents are not cleared.
module adc_round_robin_channel_fifos_top import adcrr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                   in_enable_flag,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TABLE_W-1:0]     cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CH_W-1:0]        out_selected_channel,
  output logic                   out_start_conversion,
  output logic [CH_W-1:0]        out_sample_channel,
  output logic                   out_pop_valid,
  output logic [SAMPLE_BITS-1:0] out_pop_data,
  output logic [DROP_W-1:0]      out_drop_count,
  output logic [TOTAL_W-1:0]     out_tick_total,
  output logic [TOTAL_W-1:0]     out_sample_total
);

  logic cq_valid;
  cmd_t cq_cmd;
  logic cq_pop;
  res_t res;

  adcrr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .in_enable_flag  (in_enable_flag),
    .cq_valid        (cq_valid),
    .cq_cmd          (cq_cmd),
    .cq_pop          (cq_pop)
  );

  adcrr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_valid  (cq_valid),
    .cq_cmd    (cq_cmd),
    .cq_pop    (cq_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_selected_channel = res.selected_channel;
  assign out_start_conversion = res.start_conversion;
  assign out_sample_channel   = res.sample_channel;
  assign out_pop_valid        = res.pop_valid;
  assign out_pop_data         = res.pop_data;
  assign out_drop_count       = res.drop_count;
  assign out_tick_total       = res.tick_total;
  assign out_sample_total     = res.sample_total;

endmodule

@@ bench/tb.sv @@
// self-checking bench for the adc round-robin sequencer with per-channel sample queues
module tb;
  import adcrr_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [REQ_W-1:0]       kind;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_BITS-1:0] value;
    logic                   en;
  } req_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       in_req_type = '0;
  logic [CH_W-1:0]        in_channel = '0;
  logic [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic                   in_enable_flag = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [TABLE_W-1:0]     cfg_wdata = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CH_W-1:0]        out_selected_channel;
  logic                   out_start_conversion;
  logic [CH_W-1:0]        out_sample_channel;
  logic                   out_pop_valid;
  logic [SAMPLE_BITS-1:0] out_pop_data;
  logic [DROP_W-1:0]      out_drop_count;
  logic [TOTAL_W-1:0]     out_tick_total;
  logic [TOTAL_W-1:0]     out_sample_total;

  adc_round_robin_channel_fifos_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_channel           (in_channel),
    .in_sample_value      (in_sample_value),
    .in_enable_flag       (in_enable_flag),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_selected_channel (out_selected_channel),
    .out_start_conversion (out_start_conversion),
    .out_sample_channel   (out_sample_channel),
    .out_pop_valid        (out_pop_valid),
    .out_pop_data         (out_pop_data),
    .out_drop_count       (out_drop_count),
    .out_tick_total       (out_tick_total),
    .out_sample_total     (out_sample_total)
  );

  always #5 clk = ~clk;

  // sequencer state as the bench sees it
  logic [LEN_W-1:0]       sched_len = '0;
  logic [TABLE_W-1:0]     sched_table = '0;
  logic [3:0]             sched_pos = '0;
  logic [CH_W-1:0]        cur_ch = '0;
  logic [TOTAL_W-1:0]     tick_cnt = '0;
  logic [TOTAL_W-1:0]     sample_cnt = '0;
  logic [SAMPLE_BITS-1:0] queue_data [NUM_CHANNELS][FIFO_DEPTH];
  int unsigned            wr_slot [NUM_CHANNELS];
  int unsigned            rd_slot [NUM_CHANNELS];
  int unsigned            fill [NUM_CHANNELS];
  logic [DROP_W-1:0]      drops [NUM_CHANNELS];
  bit                     queue_on [NUM_CHANNELS];

  req_word_t   request_backlog [$];
  res_t        due_results [$];
  req_word_t   cur_req;
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  stall_cycle = '0;
  logic        no_gaps = 1'b0;
  logic        hold_kick = 1'b0;

  initial begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      wr_slot[c] = 0;
      rd_slot[c] = 0;
      fill[c] = 0;
      drops[c] = '0;
      queue_on[c] = 1'b1;
    end
  end

  // works out the result word of one accepted request and files it
  task automatic advance_sequencer(input req_word_t r);
    res_t        w;
    int unsigned len;
    int unsigned pos;
    logic [CH_W-1:0] c;
    w = '0;
    case (r.kind)
      REQ_TICK: begin
        tick_cnt++;
        if (sched_len != 0) begin
          len = (sched_len > SCHED_ENTRIES) ? SCHED_ENTRIES : sched_len;
          pos = sched_pos + 1;
          if (pos >= len) pos = 0;
          sched_pos = 4'(pos);
          cur_ch = sched_table[sched_pos*CH_W +: CH_W];
          w.start_conversion = 1'b1;
        end
        w.drop_count = (cur_ch < NUM_CHANNELS) ? drops[cur_ch] : '0;
      end
      REQ_SAMPLE: begin
        c = cur_ch;
        sample_cnt++;
        w.sample_channel = c;
        if (c < NUM_CHANNELS && queue_on[c]) begin
          if (fill[c] < FIFO_DEPTH) begin
            queue_data[c][wr_slot[c]] = r.value;
            wr_slot[c] = (wr_slot[c] + 1) % FIFO_DEPTH;
            fill[c]++;
          end else begin
            drops[c]++;
          end
        end
        w.drop_count = (c < NUM_CHANNELS) ? drops[c] : '0;
      end
      REQ_POP: begin
        if (r.ch < NUM_CHANNELS && fill[r.ch] > 0) begin
          w.pop_data = queue_data[r.ch][rd_slot[r.ch]];
          w.pop_valid = 1'b1;
          rd_slot[r.ch] = (rd_slot[r.ch] + 1) % FIFO_DEPTH;
          fill[r.ch]--;
        end
        w.drop_count = (r.ch < NUM_CHANNELS) ? drops[r.ch] : '0;
      end
      REQ_ENABLE: begin
        if (r.ch < NUM_CHANNELS) begin
          queue_on[r.ch] = r.en;
          // switching off throws away what is queued
          if (!r.en) begin
            wr_slot[r.ch] = 0;
            rd_slot[r.ch] = 0;
            fill[r.ch] = 0;
          end
        end
        w.drop_count = (r.ch < NUM_CHANNELS) ? drops[r.ch] : '0;
      end
    endcase
    w.selected_channel = cur_ch;
    w.tick_total = tick_cnt;
    w.sample_total = sample_cnt;
    due_results.push_back(w);
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_sequencer(cur_req);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !no_gaps) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = request_backlog.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_req.kind;
          in_channel <= cur_req.ch;
          in_sample_value <= cur_req.value;
          in_enable_flag <= cur_req.en;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      stall_cycle <= stall_cycle + 8'd1;
      if (hold_kick) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_cycle[7:6])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 2) == 0);
          2'd2: out_stall <= stall_cycle[0];
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: each result word against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("selected_channel", 32'(want.selected_channel),
                    32'(out_selected_channel));
        check_field("start_conversion", 32'(want.start_conversion),
                    32'(out_start_conversion));
        check_field("sample_channel", 32'(want.sample_channel), 32'(out_sample_channel));
        check_field("pop_valid", 32'(want.pop_valid), 32'(out_pop_valid));
        check_field("pop_data", 32'(want.pop_data), 32'(out_pop_data));
        check_field("drop_count", 32'(want.drop_count), 32'(out_drop_count));
        check_field("tick_total", want.tick_total, out_tick_total);
        check_field("sample_total", want.sample_total, out_sample_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic push_req(input logic [REQ_W-1:0] kind, input int unsigned ch,
                          input int unsigned value, input bit en);
    req_word_t r;
    r.kind = kind;
    r.ch = ch[CH_W-1:0];
    r.value = value[SAMPLE_BITS-1:0];
    r.en = en;
    request_backlog.push_back(r);
    queued_total++;
  endtask

  // pops and enables mostly aim at channels the schedule visits
  function automatic req_word_t rand_req();
    req_word_t   r;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.kind = REQ_TICK;
    else if (pick < 60) r.kind = REQ_SAMPLE;
    else if (pick < 90) r.kind = REQ_POP;
    else r.kind = REQ_ENABLE;
    r.ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    r.value = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    r.en = ($urandom_range(0, 3) != 0);
    n = (sched_len > SCHED_ENTRIES) ? SCHED_ENTRIES : sched_len;
    if ((r.kind == REQ_POP || r.kind == REQ_ENABLE) && $urandom_range(0, 3) != 0) begin
      if (n == 0) r.ch = cur_ch;
      else r.ch = sched_table[$urandom_range(0, n - 1)*CH_W +: CH_W];
    end
    return r;
  endfunction

  task automatic queue_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      request_backlog.push_back(rand_req());
      queued_total++;
    end
  endtask

  // waits until every word is taken and answered, then lets the pipe drain
  task automatic settle();
    while (accepted_total != queued_total || due_results.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCHED_LEN: sched_len = data[LEN_W-1:0];
      default: sched_table = data;
    endcase
    @(posedge clk);
  endtask

  task automatic reconfigure(input int unsigned len, input logic [TABLE_W-1:0] tbl);
    settle();
    cfg_write(CFG_SCHED_LEN, TABLE_W'(len));
    cfg_write(CFG_SCHED_TABLE, tbl);
    @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no schedule yet: tick without start, fill channel 0 past full
    push_req(REQ_TICK, 0, 0, 0);
    push_req(REQ_SAMPLE, 0, 0, 0);
    push_req(REQ_SAMPLE, 0, 1023, 0);
    push_req(REQ_SAMPLE, 0, 'h2aa, 0);
    push_req(REQ_SAMPLE, 0, 'h155, 0);
    push_req(REQ_SAMPLE, 0, 'h3ff, 1);
    repeat (5) push_req(REQ_POP, 0, 0, 0);
    push_req(REQ_POP, 15, 0, 0);
    // disabled queue takes nothing, disabling a filled queue empties it
    push_req(REQ_ENABLE, 0, 0, 0);
    push_req(REQ_SAMPLE, 0, 'h123, 0);
    push_req(REQ_POP, 0, 0, 0);
    push_req(REQ_ENABLE, 0, 0, 1);
    push_req(REQ_SAMPLE, 0, 'h0ab, 0);
    push_req(REQ_ENABLE, 0, 0, 0);
    push_req(REQ_ENABLE, 0, 0, 1);
    push_req(REQ_POP, 0, 0, 0);
    push_req(REQ_ENABLE, 15, 1023, 1);

    reconfigure(3, 64'hfedc_ba98_7654_3210);
    // walk the short schedule through its wrap
    repeat (3) push_req(REQ_TICK, 15, 1023, 1);
    push_req(REQ_SAMPLE, 0, 'h200, 0);
    queue_random(80);

    // full schedule while the receiver holds off and the sender keeps offering
    reconfigure(16, {$urandom, $urandom});
    no_gaps <= 1'b1;
    hold_kick <= 1'b1;
    queue_random(80);
    @(posedge clk);
    hold_kick <= 1'b0;
    settle();
    no_gaps <= 1'b0;

    // over-long length acts as the whole table
    reconfigure(31, '1);
    queue_random(60);
    // shorter length than the current position wraps on the next tick
    reconfigure(2, '0);
    queue_random(60);
    reconfigure(0, {$urandom, $urandom});
    queue_random(60);
    reconfigure(1, {$urandom, $urandom});
    queue_random(60);
    repeat (4) begin
      reconfigure(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16),
                  {$urandom, $urandom});
      queue_random(50);
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
